### design/isl_pkg.sv
`default_nettype none

package isl_pkg;

	localparam int DEF_CAPACITY     = 16;
	localparam int DEF_HANDLE_WIDTH = 32;

	localparam int REQ_TYPE_W = 3;
	localparam int POS_W      = 4;
	localparam int PORT_HW    = 32;
	localparam int FILL_W     = 5;
	localparam int STATUS_W   = 2;

	localparam logic [REQ_TYPE_W-1:0] REQ_PUSH   = 3'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 3'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_POP    = 3'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE = 3'd3;
	localparam logic [REQ_TYPE_W-1:0] REQ_READ   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [POS_W-1:0]      position;
		logic [PORT_HW-1:0]    handle_in;
	} req_t;

	typedef struct packed {
		logic [PORT_HW-1:0]  handle_out;
		logic [FILL_W-1:0]   fill_count;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PUSH,
		OP_INSERT,
		OP_POP,
		OP_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [POS_W-1:0] pos;
	} cell_cmd_t;

endpackage

`default_nettype wire

### design/indexed_shift_list.sv
// A result word is registered and appears on rsp in the cycle after its request is accepted.
// Throughput: one request per cycle while rsp is not stalled; every cell of the
// row updates in the same cycle, so shifts take no extra time.
// Reset clears the entry count and the result valid flag; stored entries are
// undefined until written and need no clearing pass.
`default_nettype none

module indexed_shift_list #(
	parameter int CAPACITY     = isl_pkg::DEF_CAPACITY,
	parameter int HANDLE_WIDTH = isl_pkg::DEF_HANDLE_WIDTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire isl_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output isl_pkg::rsp_t      rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W = ((CNT_W > isl_pkg::POS_W) ? CNT_W : isl_pkg::POS_W) + 1;

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	isl_pkg::rsp_t    rsp_q;

	logic [HANDLE_WIDTH-1:0] cell_val [CAPACITY];
	logic [HANDLE_WIDTH-1:0] new_handle;
	logic [HANDLE_WIDTH-1:0] rd_val;
	logic [IDX_W-1:0]        rd_addr;

	logic [CMP_W-1:0]            cnt_w;
	logic [CMP_W-1:0]            pos_w;
	logic                        full;
	logic                        empty;
	logic                        in_range;
	logic                        accept;
	logic                        hout_sel;
	isl_pkg::cell_op_t           op;
	isl_pkg::cell_cmd_t          cmd;
	logic [CNT_W-1:0]            count_next;
	logic [isl_pkg::STATUS_W-1:0] status;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign cnt_w      = CMP_W'(count_q);
	assign pos_w      = CMP_W'(req.position);
	assign full       = cnt_w >= CMP_W'(CAPACITY);
	assign empty      = count_q == '0;
	assign in_range   = pos_w < cnt_w;
	assign new_handle = HANDLE_WIDTH'(req.handle_in);

	// Pop reads the last entry; remove and read use the requested position.
	assign rd_addr = (req.req_type == isl_pkg::REQ_POP) ?
		IDX_W'(cnt_w - CMP_W'(1)) : IDX_W'(pos_w);
	assign rd_val  = cell_val[rd_addr];

	always_comb begin
		op         = isl_pkg::OP_NONE;
		status     = isl_pkg::ST_OK;
		count_next = count_q;
		hout_sel   = 1'b0;
		case (req.req_type)
			isl_pkg::REQ_PUSH: begin
				if (full) begin
					status = isl_pkg::ST_FULL;
				end else begin
					op         = isl_pkg::OP_PUSH;
					count_next = count_q + CNT_W'(1);
				end
			end
			isl_pkg::REQ_INSERT: begin
				if (full) begin
					status = isl_pkg::ST_FULL;
				end else if (!in_range) begin
					status = isl_pkg::ST_RANGE;
				end else begin
					op         = isl_pkg::OP_INSERT;
					count_next = count_q + CNT_W'(1);
				end
			end
			isl_pkg::REQ_POP: begin
				if (empty) begin
					status = isl_pkg::ST_EMPTY;
				end else begin
					op         = isl_pkg::OP_POP;
					count_next = count_q - CNT_W'(1);
					hout_sel   = 1'b1;
				end
			end
			isl_pkg::REQ_REMOVE: begin
				if (empty) begin
					status = isl_pkg::ST_EMPTY;
				end else if (!in_range) begin
					status = isl_pkg::ST_RANGE;
				end else begin
					op         = isl_pkg::OP_REMOVE;
					count_next = count_q - CNT_W'(1);
					hout_sel   = 1'b1;
				end
			end
			isl_pkg::REQ_READ: begin
				if (!in_range) begin
					status = isl_pkg::ST_RANGE;
				end else begin
					hout_sel = 1'b1;
				end
			end
			default: begin
				op = isl_pkg::OP_NONE;
			end
		endcase
	end

	assign cmd = '{op: (accept ? op : isl_pkg::OP_NONE), pos: req.position};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [HANDLE_WIDTH-1:0] left_val;
		logic [HANDLE_WIDTH-1:0] right_val;

		if (i == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_mid_l
			assign left_val = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_mid_r
			assign right_val = cell_val[i+1];
		end

		isl_cell #(
			.IDX          (i),
			.CNT_W        (CNT_W),
			.HANDLE_WIDTH (HANDLE_WIDTH)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.new_handle (new_handle),
			.left_val   (left_val),
			.right_val  (right_val),
			.val        (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.handle_out <= hout_sel ? isl_pkg::PORT_HW'(rd_val) : '0;
			rsp_q.fill_count <= isl_pkg::FILL_W'(count_next);
			rsp_q.status     <= status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### design/isl_cell.sv
`default_nettype none

module isl_cell #(
	parameter int IDX          = 0,
	parameter int CNT_W        = 5,
	parameter int HANDLE_WIDTH = isl_pkg::DEF_HANDLE_WIDTH
) (
	input  wire logic                    clk,
	input  wire isl_pkg::cell_cmd_t      cmd,
	input  wire logic [CNT_W-1:0]        count,
	input  wire logic [HANDLE_WIDTH-1:0] new_handle,
	input  wire logic [HANDLE_WIDTH-1:0] left_val,
	input  wire logic [HANDLE_WIDTH-1:0] right_val,
	output logic [HANDLE_WIDTH-1:0]      val
);

	localparam int CMP_W = ((CNT_W > isl_pkg::POS_W) ? CNT_W : isl_pkg::POS_W) + 1;
	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic [CMP_W-1:0] last_w;
	logic [HANDLE_WIDTH-1:0] entry_q;

	assign pos_w  = CMP_W'(cmd.pos);
	assign cnt_w  = CMP_W'(count);
	assign last_w = cnt_w - CMP_W'(1);

	// The cell only ever sees commands that have already passed the checks.
	always_ff @(posedge clk) begin
		case (cmd.op)
			isl_pkg::OP_PUSH: begin
				if (MY_IDX == cnt_w) begin
					entry_q <= new_handle;
				end
			end
			isl_pkg::OP_INSERT: begin
				if (MY_IDX == pos_w) begin
					entry_q <= new_handle;
				end else if (MY_IDX > pos_w && MY_IDX <= cnt_w) begin
					entry_q <= left_val;
				end
			end
			isl_pkg::OP_POP: begin
				if (MY_IDX == last_w) begin
					entry_q <= '0;
				end
			end
			isl_pkg::OP_REMOVE: begin
				if (MY_IDX == last_w) begin
					entry_q <= '0;
				end else if (MY_IDX >= pos_w && MY_IDX < last_w) begin
					entry_q <= right_val;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign val = entry_q;

endmodule

`default_nettype wire
